// ===== hw/rtl/xcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// xcpc_pkg
// Shared types, register indexes and the XORSHIFT32 step function for the
// chained XOR pixel cipher.
// ----------------------------------------------------------------------------
package xcpc_pkg;

  // Field widths.
  localparam int unsigned PixW   = 24;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 25;
  localparam int unsigned IndexW = 8;

  // Configuration register indexes.
  localparam logic [IndexW-1:0] REG_KEY_SEED     = 8'd0;
  localparam logic [IndexW-1:0] REG_START_VALUE  = 8'd1;
  localparam logic [IndexW-1:0] REG_PIXEL_COUNT  = 8'd2;
  localparam logic [IndexW-1:0] REG_DECRYPT_MODE = 8'd3;

  typedef logic [PixW-1:0]   pix_t;
  typedef logic [WordW-1:0]  word_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [IndexW-1:0] index_t;

  // Current register contents.
  typedef struct packed {
    word_t  key_seed;
    pix_t   start_value;
    count_t pixel_count;
    logic   decrypt_mode;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_skip;   // first pixel taken: seed the generator, load counter
    logic step_skip;   // one generator step of the skip phase
    logic emit_next;   // later pixel: step generator and produce a result
    logic emit_first;  // skip done: produce the first pixel's result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip_done;   // skip counter has reached zero
  } status_t;

  // One XORSHIFT32 step with shifts 13, 17 and 5.
  function automatic word_t xs_step(input word_t v);
    word_t a;
    word_t b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// ===== hw/rtl/xcpc_cfg.sv =====
// ----------------------------------------------------------------------------
// xcpc_cfg
// Configuration register file. Writes to indexes outside the list are
// accepted and dropped.
// ----------------------------------------------------------------------------
module xcpc_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  xcpc_pkg::index_t      cfg_index,
  input  xcpc_pkg::word_t       cfg_data,
  output xcpc_pkg::cfg_t        cfg
);
  import xcpc_pkg::*;

  // The register file can always take a write.
  assign cfg_ready = 1'b1;

  // Register writes, decoded by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_seed     <= word_t'(1);
      cfg.start_value  <= '0;
      cfg.pixel_count  <= count_t'(1);
      cfg.decrypt_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_SEED:     cfg.key_seed     <= cfg_data;
        REG_START_VALUE:  cfg.start_value  <= cfg_data[PixW-1:0];
        REG_PIXEL_COUNT:  cfg.pixel_count  <= cfg_data[CountW-1:0];
        REG_DECRYPT_MODE: cfg.decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/xcpc_datapath.sv =====
// ----------------------------------------------------------------------------
// xcpc_datapath
// Generator word, chain pixel, skip counter and the output pixel register.
// ----------------------------------------------------------------------------
module xcpc_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  xcpc_pkg::cfg_t        cfg,
  input  xcpc_pkg::cmd_t        cmd,
  output xcpc_pkg::status_t     status,
  input  xcpc_pkg::pix_t        pix_in,
  output xcpc_pkg::pix_t        pix_out
);
  import xcpc_pkg::*;

  word_t  generator_word;
  pix_t   chain_pixel;
  count_t skip_counter;
  pix_t   first_hold;
  pix_t   out_pix;
  word_t  gen_stepped;
  pix_t   res_next;
  pix_t   res_first;

  assign gen_stepped = xs_step(generator_word);

  // Result of a later pixel uses the freshly stepped word and the chain.
  assign res_next  = chain_pixel ^ pix_in ^ gen_stepped[PixW-1:0];
  // Result of the first pixel uses the word left by the skip phase.
  assign res_first = cfg.start_value ^ first_hold ^ generator_word[PixW-1:0];

  assign status.skip_done = (skip_counter == '0);
  assign pix_out          = out_pix;

  // Generator and chain state.
  always_ff @(posedge clk) begin
    if (rst) begin
      generator_word <= '0;
      chain_pixel    <= '0;
      skip_counter   <= '0;
    end else begin
      if (cmd.load_skip) begin
        generator_word <= cfg.key_seed;
        skip_counter   <= cfg.pixel_count;
      end else if (cmd.step_skip) begin
        generator_word <= gen_stepped;
        skip_counter   <= skip_counter - count_t'(1);
      end else if (cmd.emit_next) begin
        generator_word <= gen_stepped;
        chain_pixel    <= cfg.decrypt_mode ? pix_in : res_next;
      end else if (cmd.emit_first) begin
        chain_pixel    <= cfg.decrypt_mode ? first_hold : res_first;
      end
    end
  end

  // Payload registers: held first pixel and the output pixel.
  always_ff @(posedge clk) begin
    if (cmd.load_skip) begin
      first_hold <= pix_in;
    end
    if (cmd.emit_next) begin
      out_pix <= res_next;
    end else if (cmd.emit_first) begin
      out_pix <= res_first;
    end
  end

endmodule

// ===== hw/rtl/xcpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// xcpc_ctrl
// Controller: stream handshakes, the skip phase sequencing and the output
// valid flag.
// ----------------------------------------------------------------------------
module xcpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_first,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  xcpc_pkg::status_t     status,
  output xcpc_pkg::cmd_t        cmd
);
  import xcpc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SKIP = 1'b1;

  logic state;
  logic state_next;
  logic out_free;
  logic in_take;

  // The output register can be loaded when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign in_take  = in_valid && in_ready;

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (in_first) begin
            cmd.load_skip = 1'b1;
            state_next    = ST_SKIP;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      ST_SKIP: begin
        if (!status.skip_done) begin
          cmd.step_skip = 1'b1;
        end else if (out_free) begin
          cmd.emit_first = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit_next || cmd.emit_first) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/xorshift_chained_xor_pixel_cipher.sv =====
// ----------------------------------------------------------------------------
// xorshift_chained_xor_pixel_cipher
// Chained XOR pixel cipher with an XORSHIFT32 keystream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the slave stream (s_tdata: blue, green, red from bit 0;
//   s_tuser: first pixel of a frame) and leave on the master stream
//   (m_tdata: blue, green, red from bit 0). Every transaction on the slave
//   side yields exactly one transaction on the master side.
//   Registers (key seed, start value, pixel count, decrypt mode) are to be
//   set by the user on the cfg channel while no pixel is in flight; the
//   block does not enforce this. The cfg channel is always ready. A later
//   pixel of a frame is loaded into the output register at the edge that
//   takes it, so m_tvalid rises in the next cycle and the stream runs at one
//   pixel per cycle while the receiver does not stall. A first pixel starts
//   the skip phase: the generator is stepped pixel_count times, once per
//   cycle, by the shared step unit; no input is taken until its result
//   is loaded. When the receiver stalls, the result waits in the output
//   register and new input is refused until it has been taken or is being
//   taken. Reset clears the generator word and chain to zero, loads the
//   register reset values and empties the output register.
// ----------------------------------------------------------------------------
module xorshift_chained_xor_pixel_cipher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // blue_in, green_in, red_in
  input  logic                  s_tuser,   // first_pixel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // blue_out, green_out, red_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  xcpc_pkg::index_t      cfg_index,
  input  xcpc_pkg::word_t       cfg_data
);
  import xcpc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers.
  xcpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake and sequencing control.
  xcpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_first  (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Generator, chain and output pixel.
  xcpc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status),
    .pix_in  (s_tdata),
    .pix_out (m_tdata)
  );

endmodule
